>>> hw/rtl/complex_fir_decimator_top_assert.svh
// Assertion macros used by the execution unit (cfd_back) of the complex FIR decimator.
`ifndef COMPLEX_FIR_DECIMATOR_TOP_ASSERT_SVH
`define COMPLEX_FIR_DECIMATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex FIR decimator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex FIR decimator sequence check failed");

`endif

>>> hw/rtl/cfd_pkg.sv
package cfd_pkg;

    localparam int MAX_TAPS    = 256;
    localparam int MAX_DECIM   = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int TAP_W       = 16;
    localparam int FRAC_BITS   = 15;
    localparam int CMD_W       = 2;
    localparam int TAP_IDX_W   = 8;
    localparam int DECIM_REG_W = 7;
    localparam int TAPS_REG_W  = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int HIST_DEPTH  = 1 << TAP_AW;
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int PHASE_W     = $clog2(MAX_DECIM + 1);
    localparam int PROD_W      = TAP_W + SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + TAP_AW + 1;
    localparam int QUO_W       = ACC_W + 1 - FRAC_BITS;

    localparam int INQ_DEPTH   = 4;
    localparam int INQ_AW      = $clog2(INQ_DEPTH);
    localparam int OUTQ_DEPTH  = 2;
    localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DECIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 1'd1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_TAP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind                       kind;
        logic [TAP_AW-1:0]              tap_addr;
        logic signed [TAP_W-1:0]        tap_value;
        logic signed [SAMPLE_BITS-1:0]  sample_i;
        logic signed [SAMPLE_BITS-1:0]  sample_q;
    } t_op;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
    } t_res;

    typedef struct packed {
        logic [PHASE_W-1:0] decim;
        logic [CNT_W-1:0]   taps;
    } t_cfg;

    // Round half up, drop the fraction bits and saturate to the sample width.
    function automatic logic signed [SAMPLE_BITS-1:0] finish_acc(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]   v;
        logic signed [QUO_W-1:0] q;
        logic signed [QUO_W-1:0] hi;
        logic signed [QUO_W-1:0] lo;
        hi = QUO_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -QUO_W'(1 << (SAMPLE_BITS - 1));
        v  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
        q  = v[ACC_W:FRAC_BITS];
        if (q > hi) begin
            finish_acc = hi[SAMPLE_BITS-1:0];
        end else if (q < lo) begin
            finish_acc = lo[SAMPLE_BITS-1:0];
        end else begin
            finish_acc = q[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/cfd_front.sv
module cfd_front
    import cfd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [CMD_W-1:0]              i_command,
    input  logic [TAP_IDX_W-1:0]          i_tap_index,
    input  logic signed [TAP_W-1:0]       i_tap_value,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    output logic                          o_full,
    output logic                          o_empty,
    output t_op                           o_op,
    input  logic                          i_pop
);

    t_op                r_q [INQ_DEPTH];
    logic [INQ_AW-1:0]  r_wp;
    logic [INQ_AW-1:0]  r_rp;
    logic [INQ_AW:0]    r_cnt;
    logic               keep;
    logic               wr;
    logic               rd;
    t_op                op;

    // Decode the request; ignored commands are accepted and dropped here.
    always_comb begin
        op.tap_addr  = TAP_AW'(i_tap_index);
        op.tap_value = i_tap_value;
        op.sample_i  = i_sample_i;
        op.sample_q  = i_sample_q;
        op.kind      = OP_PUSH;
        keep         = 1'b0;
        case (i_command)
            CMD_PUSH: begin
                op.kind = OP_PUSH;
                keep    = 1'b1;
            end
            CMD_TAP: begin
                op.kind = OP_TAP;
                keep    = 32'(i_tap_index) < MAX_TAPS;
            end
            CMD_CLEAR: begin
                op.kind = OP_CLEAR;
                keep    = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full  = r_cnt == (INQ_AW + 1)'(INQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full && keep;
    assign rd      = i_pop && !o_empty;
    assign o_op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (INQ_AW + 1)'(wr) - (INQ_AW + 1)'(rd);
        end
    end

endmodule

>>> hw/rtl/cfd_outq.sv
module cfd_outq
    import cfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    t_res               r_q [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp;
    logic [OUTQ_AW-1:0] r_rp;
    logic [OUTQ_AW:0]   r_cnt;
    logic               wr;
    logic               rd;

    assign o_full  = r_cnt == (OUTQ_AW + 1)'(OUTQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_wr && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OUTQ_AW + 1)'(wr) - (OUTQ_AW + 1)'(rd);
        end
    end

endmodule

>>> hw/rtl/cfd_back.sv
`include "complex_fir_decimator_top_assert.svh"

module cfd_back
    import cfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_op_empty,
    input  t_op  i_op,
    output logic o_op_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [PHASE_W-1:0]          r_phase;
    logic [TAP_AW-1:0]           r_wp;
    logic [TAP_AW-1:0]           r_fill;
    logic [TAP_AW-1:0]           r_base;
    logic [TAP_AW-1:0]           r_fill_snap;
    logic [CNT_W-1:0]            r_j;
    logic [CNT_W-1:0]            r_k;
    logic                        r_s1_v;
    logic                        r_s1_z;
    logic                        r_s2_v;
    logic signed [TAP_W-1:0]     r_tap_rd;
    logic [2*SAMPLE_BITS-1:0]    r_hist_rd;
    logic signed [PROD_W-1:0]    r_p_i;
    logic signed [PROD_W-1:0]    r_p_q;
    logic signed [ACC_W-1:0]     r_acc_i;
    logic signed [ACC_W-1:0]     r_acc_q;
    logic signed [TAP_W-1:0]     r_tap_mem [MAX_TAPS];
    logic [2*SAMPLE_BITS-1:0]    r_hist_mem [HIST_DEPTH];

    logic                        fire;
    logic                        blocked;
    logic                        start;
    logic                        issue;
    logic                        last;
    logic [TAP_AW-1:0]           hist_ra;
    logic signed [SAMPLE_BITS-1:0] hist_i;
    logic signed [SAMPLE_BITS-1:0] hist_q;

    assign fire     = r_phase <= PHASE_W'(1);
    assign blocked  = i_op.kind == OP_PUSH && fire && i_res_full;
    assign o_op_pop = r_state == ST_IDLE && !i_op_empty && !blocked;
    assign start    = o_op_pop && i_op.kind == OP_PUSH && fire;
    assign issue    = r_state == ST_MAC;
    assign last     = r_j == r_k - 1'b1;
    assign hist_ra  = r_base - r_j[TAP_AW-1:0];
    assign hist_i   = r_hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign hist_q   = r_hist_rd[SAMPLE_BITS-1:0];

    assign o_res_push  = r_state == ST_DRAIN && !r_s1_v && !r_s2_v;
    assign o_res.out_i = finish_acc(r_acc_i);
    assign o_res.out_q = finish_acc(r_acc_q);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (o_res_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Tap and history memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (o_op_pop && i_op.kind == OP_TAP) begin
            r_tap_mem[i_op.tap_addr] <= i_op.tap_value;
        end
        if (o_op_pop && i_op.kind == OP_PUSH) begin
            r_hist_mem[r_wp] <= {i_op.sample_i, i_op.sample_q};
        end
        r_tap_rd  <= r_tap_mem[r_j[TAP_AW-1:0]];
        r_hist_rd <= r_hist_mem[hist_ra];
    end

    // Multiply stage; entries older than the fill level read as zero.
    always_ff @(posedge i_clk) begin
        r_p_i <= r_s1_z ? '0 : PROD_W'(r_tap_rd) * PROD_W'(hist_i);
        r_p_q <= r_s1_z ? '0 : PROD_W'(r_tap_rd) * PROD_W'(hist_q);
        r_s1_z <= r_j > CNT_W'(r_fill_snap);
        if (start) begin
            r_acc_i     <= '0;
            r_acc_q     <= '0;
            r_base      <= r_wp;
            r_fill_snap <= r_fill;
            r_k         <= i_cfg.taps;
        end else if (r_s2_v) begin
            r_acc_i <= r_acc_i + ACC_W'(r_p_i);
            r_acc_q <= r_acc_q + ACC_W'(r_p_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PHASE_W'(1);
            r_wp    <= '0;
            r_fill  <= '0;
            r_j     <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= issue;
            r_s2_v  <= r_s1_v;
            if (start) begin
                r_j <= '0;
            end else if (issue && !last) begin
                r_j <= r_j + 1'b1;
            end
            if (o_op_pop) begin
                case (i_op.kind)
                    OP_PUSH: begin
                        r_phase <= fire ? i_cfg.decim : r_phase - 1'b1;
                        r_wp    <= r_wp + 1'b1;
                        if (32'(r_fill) < MAX_TAPS - 1) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        r_phase <= i_cfg.decim;
                        r_fill  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    `CFD_ASSERT_IMP(a_res_room, i_clk, i_rst_n, o_res_push, !i_res_full)
    `CFD_ASSERT_IMP(a_phase_nz, i_clk, i_rst_n, 1'b1, r_phase != '0)
    `CFD_ASSERT_IMP(a_busy_no_pop, i_clk, i_rst_n, r_state != ST_IDLE, !o_op_pop)
    `CFD_ASSERT_IMP(a_tap_bound, i_clk, i_rst_n, r_state == ST_MAC, r_j < r_k)
    `CFD_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_res_push, r_state == ST_IDLE && !r_s1_v)

endmodule

>>> hw/rtl/complex_fir_decimator_top.sv
// Complex FIR decimator with real taps. Requests enter through a queue-style
// port (push/full) and are taken in order: command 0 pushes an I/Q sample,
// command 1 writes one signed Q1.15 tap, command 2 clears the sample history
// and reloads the decimation phase, and command 3 is dropped. Every
// decimation-th sample produces one result on the queue-style output
// (empty/pop): the taps applied to that sample and the samples before it,
// accumulated at full width, rounded half up, scaled down by 2^15 and
// saturated to 16 bits. A tap request, a clear request or a sample that
// produces no result is carried out as it is popped. A sample that produces
// a result occupies the execution unit until its result is pushed, because one
// shared multiply-accumulate pair (one multiplier each for I and for Q) walks
// the taps one per cycle through the tap and history memories; no new request
// is popped meanwhile. A four-entry request queue sits in front of the
// execution unit and a two-entry result queue behind it, so the input keeps
// taking requests while a result waits to be popped. Taps must be written
// before they are used; the history reads as zero after reset and after a
// clear request. The user must write the decimation and tap_count registers
// through the configuration port only while the block is idle; the block
// itself does not enforce this. A decimation change takes effect at the next
// reload of the phase counter.
module complex_fir_decimator_top
    import cfd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [CMD_W-1:0]              i_command,
    input  logic [TAP_IDX_W-1:0]          i_tap_index,
    input  logic signed [TAP_W-1:0]       i_tap_value,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_out_i,
    output logic signed [SAMPLE_BITS-1:0] o_out_q,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic [DECIM_REG_W-1:0] r_decim;
    logic [TAPS_REG_W-1:0]  r_taps;
    t_cfg                   cfg;
    t_op                    op;
    logic                   op_empty;
    logic                   op_pop;
    logic                   res_full;
    logic                   res_push;
    t_res                   res_in;
    t_res                   res_out;

    // Configuration registers, written directly with no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= DECIM_REG_W'(1);
            r_taps  <= TAPS_REG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DECIM: r_decim <= i_cfg_data[DECIM_REG_W-1:0];
                REG_TAPS:  r_taps  <= i_cfg_data[TAPS_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero setting behaves as one, and settings above the supported
    // maximum are clamped to it.
    always_comb begin
        if (r_decim == '0) begin
            cfg.decim = PHASE_W'(1);
        end else if (32'(r_decim) > MAX_DECIM) begin
            cfg.decim = PHASE_W'(MAX_DECIM);
        end else begin
            cfg.decim = PHASE_W'(r_decim);
        end
        if (r_taps == '0) begin
            cfg.taps = CNT_W'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            cfg.taps = CNT_W'(MAX_TAPS);
        end else begin
            cfg.taps = CNT_W'(r_taps);
        end
    end

    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_command   (i_command),
        .i_tap_index (i_tap_index),
        .i_tap_value (i_tap_value),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .o_full      (full),
        .o_empty     (op_empty),
        .o_op        (op),
        .i_pop       (op_pop)
    );

    cfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op_empty (op_empty),
        .i_op       (op),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    cfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_out_i = res_out.out_i;
    assign o_out_q = res_out.out_q;

endmodule

>>> tb/cfd_checker.sv
module cfd_checker
    import cfd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [CMD_W-1:0]              i_command,
    input  logic [TAP_IDX_W-1:0]          i_tap_index,
    input  logic signed [TAP_W-1:0]       i_tap_value,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  logic signed [SAMPLE_BITS-1:0] i_out_i,
    input  logic signed [SAMPLE_BITS-1:0] i_out_q,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DECIM_REG_W-1:0]        decim_reg;
    logic [TAPS_REG_W-1:0]         taps_reg;
    logic signed [TAP_W-1:0]       coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_i [MAX_TAPS-1];
    logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS-1];
    int                            phase;
    t_res                          filtered_q [$];

    function automatic int decim_in_use(logic [DECIM_REG_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DECIM) return MAX_DECIM;
        return int'(d);
    endfunction

    function automatic int taps_in_use(logic [TAPS_REG_W-1:0] t);
        if (t == 0) return 1;
        if (t > MAX_TAPS) return MAX_TAPS;
        return int'(t);
    endfunction

    // Round half up, floor away the Q1.15 fraction, then clamp to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(longint acc);
        longint v;
        v = (acc + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_res   want;
        longint acc_i;
        longint acc_q;
        int     ntaps;
        if (!i_rst_n) begin
            decim_reg = DECIM_REG_W'(1);
            taps_reg  = TAPS_REG_W'(256);
            phase     = 1;
            foreach (coef[j]) coef[j] = '0;
            foreach (hist_i[j]) begin
                hist_i[j] = '0;
                hist_q[j] = '0;
            end
            filtered_q.delete();
            o_fail_count   = 0;
            o_result_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DECIM) decim_reg = i_cfg_data[DECIM_REG_W-1:0];
                else if (i_cfg_index == REG_TAPS) taps_reg = i_cfg_data[TAPS_REG_W-1:0];
            end
            if (i_push && !i_full) begin
                case (i_command)
                    CMD_TAP: coef[i_tap_index] = i_tap_value;
                    CMD_CLEAR: begin
                        foreach (hist_i[j]) begin
                            hist_i[j] = '0;
                            hist_q[j] = '0;
                        end
                        phase = decim_in_use(decim_reg);
                    end
                    CMD_PUSH: begin
                        if (phase <= 1) begin
                            ntaps = taps_in_use(taps_reg);
                            acc_i = longint'(coef[0]) * longint'(i_sample_i);
                            acc_q = longint'(coef[0]) * longint'(i_sample_q);
                            for (int j = 1; j < ntaps; j++) begin
                                acc_i += longint'(coef[j]) * longint'(hist_i[j-1]);
                                acc_q += longint'(coef[j]) * longint'(hist_q[j-1]);
                            end
                            want.out_i = round_saturate(acc_i);
                            want.out_q = round_saturate(acc_q);
                            filtered_q.push_back(want);
                            o_result_count++;
                            phase = decim_in_use(decim_reg);
                        end else begin
                            phase--;
                        end
                        for (int j = MAX_TAPS - 2; j > 0; j--) begin
                            hist_i[j] = hist_i[j-1];
                            hist_q[j] = hist_q[j-1];
                        end
                        hist_i[0] = i_sample_i;
                        hist_q[0] = i_sample_q;
                    end
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result out_i=%0d out_q=%0d", i_out_i, i_out_q);
                    o_fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_out_i !== want.out_i) begin
                        $error("out_i: expected %0d, got %0d", want.out_i, i_out_i);
                        o_fail_count++;
                    end
                    if (i_out_q !== want.out_q) begin
                        $error("out_q: expected %0d, got %0d", want.out_q, i_out_q);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

>>> tb/tb.sv
module tb;
    import cfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Command 3 has no name in the package; the block must drop it silently.
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    // The settle time covers a result walking every tap, plus room for the queues.
    localparam int SETTLE_CYCLES = 400;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [CMD_W-1:0]              i_command = '0;
    logic [TAP_IDX_W-1:0]          i_tap_index = '0;
    logic signed [TAP_W-1:0]       i_tap_value = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_i = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_q = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_out_i;
    logic signed [SAMPLE_BITS-1:0] o_out_q;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    int fail_count;
    int pending;
    int result_count;
    int burst_left = 0;

    complex_fir_decimator_top u_top (.*);

    cfd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_command(i_command), .i_tap_index(i_tap_index), .i_tap_value(i_tap_value),
        .i_sample_i(i_sample_i), .i_sample_q(i_sample_q), .i_empty(empty), .i_pop(pop),
        .i_out_i(o_out_i), .i_out_q(o_out_q), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between always popping, popping at random and
    // long stalls, so results pile up in the output queue and back-pressure
    // reaches the execution unit.
    initial begin
        int pop_mode;
        int cyc;
        pop_mode = 0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 64 == 0) pop_mode = int'($urandom_range(0, 2));
            cyc++;
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 19) == 0);
            endcase
        end
    end

    // Sends one request. The sender runs in bursts; between bursts push may drop
    // for a random gap. Within a burst push stays high from one request to the
    // next. Full is stable between edges, so acceptance is judged at the edge.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [TAP_IDX_W-1:0] idx,
                                logic signed [TAP_W-1:0] coef,
                                logic signed [SAMPLE_BITS-1:0] si,
                                logic signed [SAMPLE_BITS-1:0] sq);
        int gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 20));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        push        <= 1'b1;
        i_command   <= cmd;
        i_tap_index <= idx;
        i_tap_value <= coef;
        i_sample_i  <= si;
        i_sample_q  <= sq;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
    endtask

    // Lowers push and lets the block go quiet before a register write.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Mostly small coefficients so long filters do not always saturate.
    function automatic logic signed [TAP_W-1:0] pick_coef();
        if ($urandom_range(0, 3) == 0) return TAP_W'($urandom());
        return TAP_W'($urandom_range(0, 4095) - 2048);
    endfunction

    // Random requests, mostly samples.
    task automatic run_random(int n_req);
        int r;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < n_req; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 75) cmd = CMD_PUSH;
            else if (r < 88) cmd = CMD_TAP;
            else if (r < 94) cmd = CMD_CLEAR;
            else cmd = CMD_IGNORED;
            send_request(cmd, TAP_IDX_W'($urandom()), pick_coef(), pick_sample(),
                         pick_sample());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every tap gets written first, so no filter ever reads an unset tap.
        for (int j = 0; j < MAX_TAPS; j++) begin
            send_request(CMD_TAP, TAP_IDX_W'(j), pick_coef(), '0, '0);
        end

        // Directed requests at reset settings: full-scale taps against
        // full-scale samples, the top tap index, a clear and a dropped command.
        send_request(CMD_TAP, 8'd0, 16'sh8000, '0, '0);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh8000, 16'sh8000);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh7FFF, 16'sh8000);
        send_request(CMD_TAP, 8'd0, 16'sh7FFF, '0, '0);
        send_request(CMD_TAP, 8'd1, 16'sh8000, '0, '0);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh8000, 16'sh7FFF);
        send_request(CMD_TAP, 8'd255, 16'sh7FFF, '0, '0);
        send_request(CMD_IGNORED, 8'hFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh0001, 16'shFFFF);
        send_request(CMD_CLEAR, 8'd0, '0, '0, '0);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh4000, 16'shC000);
        send_request(CMD_TAP, 8'd1, 16'sh0000, '0, '0);
        send_request(CMD_PUSH, 8'd0, '0, 16'sh0000, 16'sh0000);
        drain();

        // Decimation zero and tap count zero both behave as one; values past
        // the limits saturate; a tap count change keeps the old history.
        write_reg(REG_TAPS, 9'd8);
        run_random(20);
        drain();
        write_reg(REG_DECIM, 9'd0);
        write_reg(REG_TAPS, 9'd0);
        run_random(25);
        drain();
        write_reg(REG_DECIM, 9'd2);
        write_reg(REG_TAPS, 9'd1);
        run_random(25);
        drain();
        write_reg(REG_DECIM, 9'd64);
        write_reg(REG_TAPS, 9'd256);
        run_random(30);
        drain();
        write_reg(REG_DECIM, 9'd127);
        write_reg(REG_TAPS, 9'd511);
        run_random(30);
        drain();
        write_reg(REG_DECIM, 9'd3);
        write_reg(REG_TAPS, 9'd17);
        run_random(25);
        drain();
        write_reg(REG_DECIM, 9'd5);
        write_reg(REG_TAPS, 9'd300);
        run_random(25);
        drain();
        write_reg(REG_DECIM, 9'd1);
        write_reg(REG_TAPS, 9'd255);
        run_random(20);
        drain();
        write_reg(REG_DECIM, 9'd7);
        write_reg(REG_TAPS, 9'd64);
        run_random(30);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_front.sv
hw/rtl/cfd_outq.sv
hw/rtl/cfd_back.sv
hw/rtl/complex_fir_decimator_top.sv
tb/cfd_checker.sv
tb/tb.sv
